// File: rtl/flmt_pkg.sv
// Package: shared types, constants and helpers of the fan LED mode timer.
`default_nettype none
package flmt_pkg;

    localparam int unsigned NUM_MODES   = 5;
    localparam int unsigned MODE_W      = 3;
    localparam int unsigned WORD_W      = 55;
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned PULSE_W     = 8;
    localparam int unsigned SHIFT_W     = 5;
    localparam int unsigned PAT_W       = 8;
    localparam int unsigned PAT_IDX_W   = 3;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 8;

    localparam logic [MODE_W-1:0] MODE_MAX = 3'd4;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE_0    = 3'd0,
        CFG_MODE_1    = 3'd1,
        CFG_MODE_2    = 3'd2,
        CFG_MODE_3    = 3'd3,
        CFG_MODE_4    = 3'd4,
        CFG_FAN_PULSE = 3'd5,
        CFG_PAT_SHIFT = 3'd6
    } t_cfg_idx;

    // one packed mode entry, lowest bit last
    typedef struct packed {
        logic [MODE_W-1:0]  succ_button;
        logic [MODE_W-1:0]  succ_timeout;
        logic [COUNT_W-1:0] timeout;
        logic [PAT_W-1:0]   green;
        logic [PAT_W-1:0]   red;
        logic               fan;
    } t_mode_word;

    typedef struct packed {
        t_mode_word [NUM_MODES-1:0] mode;
        logic [PULSE_W-1:0]         fan_pulse;
        logic [SHIFT_W-1:0]         pat_shift;
    } t_cfg;

    typedef struct packed {
        logic [MODE_W-1:0] mode_index;
        logic              fan_drive;
        logic              green_led;
        logic              red_led;
    } t_result;

    localparam logic [WORD_W-1:0] MODE_0_RST = 55'd4503600241704960;
    localparam logic [WORD_W-1:0] MODE_1_RST = 55'd14636704932429313;
    localparam logic [WORD_W-1:0] MODE_2_RST = 55'd6192451330742273;
    localparam logic [WORD_W-1:0] MODE_3_RST = 55'd2251802885358079;
    localparam logic [WORD_W-1:0] MODE_4_RST = 55'd13510801953784217;
    localparam logic [PULSE_W-1:0] FAN_PULSE_RST = 8'd9;
    localparam logic [SHIFT_W-1:0] PAT_SHIFT_RST = 5'd9;

    // successor codes beyond the last mode fall back to mode 0
    function automatic logic [MODE_W-1:0] fold_successor(input logic [MODE_W-1:0] s);
        return (s > MODE_MAX) ? '0 : s;
    endfunction

endpackage
`default_nettype wire

// File: rtl/flmt_cfg_regs.sv
// Configuration registers: mode table, fan pulse length and pattern shift.
`default_nettype none
module flmt_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [flmt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [flmt_pkg::WORD_W-1:0]    i_cfg_wdata,
    output flmt_pkg::t_cfg                      o_cfg
);
    import flmt_pkg::*;

    t_mode_word         r_mode [NUM_MODES];
    logic [PULSE_W-1:0] r_fan_pulse;
    logic [SHIFT_W-1:0] r_pat_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode[0]   <= MODE_0_RST;
            r_mode[1]   <= MODE_1_RST;
            r_mode[2]   <= MODE_2_RST;
            r_mode[3]   <= MODE_3_RST;
            r_mode[4]   <= MODE_4_RST;
            r_fan_pulse <= FAN_PULSE_RST;
            r_pat_shift <= PAT_SHIFT_RST;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MODE_0, CFG_MODE_1, CFG_MODE_2, CFG_MODE_3, CFG_MODE_4: begin
                    r_mode[i_cfg_index] <= i_cfg_wdata;
                end
                CFG_FAN_PULSE: r_fan_pulse <= i_cfg_wdata[PULSE_W-1:0];
                CFG_PAT_SHIFT: r_pat_shift <= i_cfg_wdata[SHIFT_W-1:0];
                default: ; // unused index, write dropped
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_MODES; i++) begin
            o_cfg.mode[i] = r_mode[i];
        end
        o_cfg.fan_pulse = r_fan_pulse;
        o_cfg.pat_shift = r_pat_shift;
    end

endmodule
`default_nettype wire

// File: rtl/flmt_tick_core.sv
// Tick state and next-state logic: mode moves, elapsed count, LEDs, fan pulse.
`default_nettype none
module flmt_tick_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_advance,
    input  wire logic         i_button,
    input  wire logic         i_power,
    input  wire flmt_pkg::t_cfg i_cfg,
    output flmt_pkg::t_result o_result,
    output logic [flmt_pkg::MODE_W-1:0] o_mode
);
    import flmt_pkg::*;

    logic [MODE_W-1:0]  r_mode,      n_mode;
    logic [COUNT_W-1:0] r_elapsed,   n_elapsed;
    logic               r_last_btn;
    logic               r_last_pwr;
    logic [PULSE_W-1:0] r_fan_left,  n_fan_left;

    t_mode_word         w_old;
    t_mode_word         w_new;
    logic               btn_fall;
    logic               timeout_hit;
    logic [COUNT_W-1:0] shifted;
    logic [PAT_IDX_W-1:0] pat_idx;
    logic [PULSE_W-1:0] fan_cnt;

    always_comb begin
        w_old       = i_cfg.mode[r_mode];
        btn_fall    = r_last_btn & ~i_button;
        timeout_hit = (r_elapsed >= w_old.timeout);

        // button edge beats timeout
        if (btn_fall) begin
            n_mode    = fold_successor(w_old.succ_button);
            n_elapsed = '0;
        end else if (timeout_hit) begin
            n_mode    = fold_successor(w_old.succ_timeout);
            n_elapsed = '0;
        end else begin
            n_mode    = r_mode;
            n_elapsed = r_elapsed + COUNT_W'(1);
        end

        w_new   = i_cfg.mode[n_mode];
        shifted = r_elapsed >> i_cfg.pat_shift;
        pat_idx = shifted[PAT_IDX_W-1:0];

        fan_cnt    = (i_power != r_last_pwr) ? i_cfg.fan_pulse : r_fan_left;
        n_fan_left = (fan_cnt != '0) ? fan_cnt - PULSE_W'(1) : '0;

        o_result.red_led    = i_power & w_new.red[pat_idx];
        o_result.green_led  = i_power & w_new.green[pat_idx];
        o_result.fan_drive  = (fan_cnt != '0) & w_new.fan;
        o_result.mode_index = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= '0;
            r_elapsed  <= '0;
            r_last_btn <= 1'b1;
            r_last_pwr <= 1'b0;
            r_fan_left <= '0;
        end else if (i_advance) begin
            r_mode     <= n_mode;
            r_elapsed  <= n_elapsed;
            r_last_btn <= i_button;
            r_last_pwr <= i_power;
            r_fan_left <= n_fan_left;
        end
    end

    assign o_mode = r_mode;

`ifndef SYNTHESIS
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode <= MODE_MAX)
        else $error("mode register out of range");

    a_hold_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_advance |=> $stable(r_mode) && $stable(r_elapsed) && $stable(r_fan_left))
        else $error("tick state changed without a tick");

    a_move_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && (n_mode != r_mode) |=> r_elapsed == '0)
        else $error("mode moved without clearing the count");
`endif

endmodule
`default_nettype wire

// File: rtl/fan_led_mode_timer_unit.sv
// Top level: fan LED mode timer with stream ports and configuration write port.
//
// Use:
//   Each slave transaction is one timer tick: s_axis_tdata[0] is the sampled
//   button level (0 pressed), s_axis_tdata[1] the power level. Each tick
//   yields exactly one master transaction with the red and green LED drive,
//   the fan drive and the mode number after the tick.
//   Order: a tick is registered in the input stage, then its result in the
//   output register. Throughput: one tick per cycle while the receiver
//   keeps m_axis_tready high; the mode/count update is a single pass
//   of compare, table select and shift between the input and result
//   registers, and the next tick's logic sees the updated state at once.
//   Stall: while the receiver holds m_axis_tready low the result stays put;
//   the input stage still takes one more tick, then s_axis_tready drops
//   until the result is taken.
//   Reset (i_rst_n low, synchronous): mode 0, count 0, button taken as
//   released, power as low, no fan pulse; the table registers take their
//   default contents. Register writes land on the next clock edge and are
//   to be made only while no tick is in flight.
`default_nettype none
module fan_led_mode_timer_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // tick input
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [flmt_pkg::S_TDATA_W-1:0] s_axis_tdata,  // button_level, power_level, 0 pad
    // result output
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [flmt_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // red_led, green_led, fan_drive,
                                                               // mode_index[2:0], 0 pad
    // configuration write
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [flmt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [flmt_pkg::WORD_W-1:0]    i_cfg_wdata
);
    import flmt_pkg::*;

    t_cfg              cfg;
    t_result           result;
    logic [MODE_W-1:0] core_mode;

    // input stage
    logic    r_in_valid;
    logic    r_in_button;
    logic    r_in_power;
    // result stage
    logic    r_out_valid;
    t_result r_out;

    logic advance;

    assign advance       = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_button <= s_axis_tdata[0];
            r_in_power  <= s_axis_tdata[1];
        end
    end

    flmt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    flmt_tick_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_button  (r_in_button),
        .i_power   (r_in_power),
        .i_cfg     (cfg),
        .o_result  (result),
        .o_mode    (core_mode)
    );

    // result register: loads with the tick, holds while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - $bits(t_result)){1'b0}}, r_out};

`ifndef SYNTHESIS
    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid && r_out_valid)
        else $error("input stalled with a free stage");

    a_tick_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("tick produced no result");

    a_result_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.mode_index == core_mode)
        else $error("result mode differs from mode state");
`endif

endmodule
`default_nettype wire
